// ----- src/kact_pkg.sv -----
// Shared types and constants for the keyed attempt counter table.
package kact_pkg;

    localparam logic [2:0] FN_LOOKUP     = 3'd0;
    localparam logic [2:0] FN_BUMP_REG   = 3'd1;
    localparam logic [2:0] FN_CLR_REG    = 3'd2;
    localparam logic [2:0] FN_CLAIM      = 3'd3;
    localparam logic [2:0] FN_CLR_NOTICE = 3'd4;
    localparam logic [2:0] FN_CLR_MOUNT  = 3'd5;
    localparam logic [2:0] FN_BUMP_MOUNT = 3'd6;

    localparam int          KEY_CHARS   = 9;
    localparam logic [31:0] FNV_BASIS   = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME   = 32'h01000193;
    localparam logic [7:0]  COUNT_MAX   = 8'hFF;
    localparam logic [7:0]  LIMIT_RESET = 8'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] key_head;
        logic [7:0]  key_tail;
    } in_word_t;

    typedef struct packed {
        logic       found;
        logic       created;
        logic       evicted;
        logic       insert_failed;
        logic [7:0] register_count;
        logic [7:0] mount_count;
        logic       register_exhausted;
        logic       notice_flag;
        logic       raise_notice;
    } out_word_t;

endpackage

// ----- src/kact_front.sv -----
// Front end: takes a word, trims the key, hashes it and reduces the hash to an index slot.
module kact_front import kact_pkg::*; #(
    parameter int INDEX_SLOTS = 128,
    parameter int SW          = 7,
    parameter int W           = 3 + 64 + 8 + SW
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_word_t     s_data,
    output logic         q_push,
    input  logic         q_full,
    output logic [W-1:0] q_data
);
    typedef enum logic [2:0] {F_IDLE, F_HASH, F_MUL, F_SUB, F_FIX, F_PUSH} fstate_t;

    localparam logic [SW:0] NSLOT   = (SW + 1)'(INDEX_SLOTS);
    localparam logic [31:0] NSLOT32 = 32'(INDEX_SLOTS);
    // floor(2^(32+SW) / INDEX_SLOTS), at most 33 bits
    localparam logic [63:0] RECIP_W = (64'd1 << (32 + SW)) / 64'(INDEX_SLOTS);
    localparam logic [32:0] RECIP   = RECIP_W[32:0];

    fstate_t     state_reg, state_next;
    logic [2:0]  func_reg, func_next;
    logic [63:0] head_reg, head_next;
    logic [7:0]  tail_reg, tail_next;
    logic [31:0] h_reg, h_next;
    logic [3:0]  bi_reg, bi_next;
    logic [64:0] prod_reg, prod_next;
    logic [SW:0] rem_reg, rem_next;
    logic [SW-1:0] r_reg, r_next;

    logic [63:0] nh;
    logic [7:0]  nt;
    logic        alive;
    logic [7:0]  cur_b;
    logic [63:0] lo_prod;
    logic [31:0] q_est;

    // keep bytes up to the first NUL
    always_comb begin
        nh = '0;
        nt = '0;
        alive = 1'b1;
        for (int i = 0; i < 9; i++) begin
            if (i >= KEY_CHARS) alive = 1'b0;
            if (i < 8) begin
                if (s_data.key_head[8*i +: 8] == 8'd0) alive = 1'b0;
                if (alive) nh[8*i +: 8] = s_data.key_head[8*i +: 8];
            end else begin
                if (s_data.key_tail == 8'd0) alive = 1'b0;
                if (alive) nt = s_data.key_tail;
            end
        end
    end

    assign cur_b   = bi_reg[3] ? tail_reg : head_reg[8*bi_reg[2:0] +: 8];
    assign lo_prod = {32'd0, h_reg} * {32'd0, RECIP[31:0]};
    // quotient estimate is exact or one short
    assign q_est   = 32'(prod_reg >> (32 + SW));
    assign s_ready = (state_reg == F_IDLE) && en;
    assign q_push  = (state_reg == F_PUSH) && !q_full;
    assign q_data  = {func_reg, head_reg, tail_reg, r_reg};

    always_comb begin
        state_next = state_reg;
        func_next  = func_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        h_next     = h_reg;
        bi_next    = bi_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        r_next     = r_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    func_next  = s_data.func;
                    head_next  = nh;
                    tail_next  = nt;
                    h_next     = FNV_BASIS;
                    bi_next    = '0;
                    state_next = F_HASH;
                end
            end
            F_HASH: begin
                if (bi_reg == 4'(KEY_CHARS) || cur_b == 8'd0) begin
                    state_next = F_MUL;
                end else begin
                    h_next  = (h_reg ^ {24'd0, cur_b}) * FNV_PRIME;
                    bi_next = bi_reg + 4'd1;
                end
            end
            F_MUL: begin
                prod_next  = {1'b0, lo_prod} + (RECIP[32] ? {1'b0, h_reg, 32'd0} : 65'd0);
                state_next = F_SUB;
            end
            F_SUB: begin
                rem_next   = (SW + 1)'(h_reg - q_est * NSLOT32);
                state_next = F_FIX;
            end
            F_FIX: begin
                r_next     = (rem_reg >= NSLOT) ? SW'(rem_reg - NSLOT) : rem_reg[SW-1:0];
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!q_full) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        func_reg <= func_next;
        head_reg <= head_next;
        tail_reg <= tail_next;
        h_reg    <= h_next;
        bi_reg   <= bi_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        r_reg    <= r_next;
    end
endmodule

// ----- src/kact_queue.sv -----
// Two-entry queue between the front end and the table sequencer.
module kact_queue #(
    parameter int W = 82
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic         nonempty,
    output logic [W-1:0] rdata
);
    logic [W-1:0] ent_reg [2];
    logic [1:0]   cnt_reg;
    logic         wp_reg, rp_reg;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign rdata    = ent_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) ent_reg[wp_reg] <= wdata;
    end
endmodule

// ----- src/kact_back.sv -----
// Table sequencer: probing, record creation, eviction, index rebuild and result register.
module kact_back import kact_pkg::*; #(
    parameter int RECORDS     = 64,
    parameter int INDEX_SLOTS = 128,
    parameter int SW          = 7,
    parameter int W           = 3 + 64 + 8 + SW
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    input  logic [W-1:0] q_data,
    output logic         q_pop,
    input  logic [7:0]   limit,
    output logic         init_done,
    output logic         m_valid,
    input  logic         m_ready,
    output out_word_t    m_data
);
    localparam int RA   = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int IW   = $clog2(RECORDS + 1);
    localparam int NMAX = (RECORDS > INDEX_SLOTS) ? RECORDS : INDEX_SLOTS;
    localparam int CW   = $clog2(NMAX);

    typedef struct packed {
        logic [63:0]   head;
        logic [7:0]    tail;
        logic [7:0]    rc;
        logic [7:0]    mc;
        logic          notice;
        logic          valid;
        logic [SW-1:0] slot;
    } rec_t;

    typedef enum logic [4:0] {
        B_INIT, B_IDLE, B_F_RD, B_F_IX, B_F_CMP, B_MISS, B_SC_RD, B_SC_CHK, B_PICK,
        B_RB_CLR, B_RB_RD, B_RB_CHK, B_PL_RD, B_PL_CHK, B_NEW, B_APPLY, B_RESP
    } bstate_t;

    rec_t    rec_mem [RECORDS];
    logic [IW-1:0] idx_mem [INDEX_SLOTS];
    rec_t    rec_rd;
    logic [IW-1:0] idx_rd;

    logic          rec_we, idx_we;
    logic [RA-1:0] rec_wa, rec_ra;
    rec_t          rec_wd;
    logic [SW-1:0] idx_wa, idx_ra;
    logic [IW-1:0] idx_wd;

    bstate_t       state_reg, state_next;
    logic [2:0]    func_reg, func_next;
    logic [63:0]   head_reg, head_next;
    logic [7:0]    tail_reg, tail_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] s_reg, s_next;
    logic [SW-1:0] pc_reg, pc_next;
    logic [RA-1:0] k_reg, k_next;
    logic [RA-1:0] kc_reg, kc_next;
    logic [CW-1:0] ci_reg, ci_next;
    rec_t          cur_reg, cur_next;
    logic          found_reg, found_next;
    logic          created_reg, created_next;
    logic          evict_reg, evict_next;
    logic          fail_reg, fail_next;
    logic          raise_reg, raise_next;
    logic          has_rec_reg, has_rec_next;
    logic          in_rb_reg, in_rb_next;
    logic          rb_fail_reg, rb_fail_next;
    logic          inv_ok_reg, inv_ok_next, z2_ok_reg, z2_ok_next, m0_ok_reg, m0_ok_next;
    logic [RA-1:0] inv_k_reg, inv_k_next, z2_k_reg, z2_k_next, m0_k_reg, m0_k_next;
    logic          mv_reg, mv_next;
    out_word_t     out_reg, out_next;

    logic [SW-1:0] s_inc;
    logic          rb_step;
    rec_t          upd;
    logic          upd_raise;

    assign s_inc     = (s_reg == SW'(INDEX_SLOTS - 1)) ? '0 : s_reg + SW'(1);
    assign init_done = (state_reg != B_INIT);
    assign m_valid   = mv_reg;
    assign m_data    = out_reg;

    // op applied to the located record
    always_comb begin
        upd       = cur_reg;
        upd_raise = 1'b0;
        unique case (func_reg)
            FN_BUMP_REG:   if (cur_reg.rc != COUNT_MAX) upd.rc = cur_reg.rc + 8'd1;
            FN_CLR_REG:    upd.rc = '0;
            FN_CLAIM: begin
                if (!cur_reg.notice) begin
                    upd.notice = 1'b1;
                    upd_raise  = 1'b1;
                end
            end
            FN_CLR_NOTICE: upd.notice = 1'b0;
            FN_CLR_MOUNT:  upd.mc = '0;
            FN_BUMP_MOUNT: if (cur_reg.mc != COUNT_MAX) upd.mc = cur_reg.mc + 8'd1;
            default: ;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        slot_next    = slot_reg;
        s_next       = s_reg;
        pc_next      = pc_reg;
        k_next       = k_reg;
        kc_next      = kc_reg;
        ci_next      = ci_reg;
        cur_next     = cur_reg;
        found_next   = found_reg;
        created_next = created_reg;
        evict_next   = evict_reg;
        fail_next    = fail_reg;
        raise_next   = raise_reg;
        has_rec_next = has_rec_reg;
        in_rb_next   = in_rb_reg;
        rb_fail_next = rb_fail_reg;
        inv_ok_next  = inv_ok_reg;
        z2_ok_next   = z2_ok_reg;
        m0_ok_next   = m0_ok_reg;
        inv_k_next   = inv_k_reg;
        z2_k_next    = z2_k_reg;
        m0_k_next    = m0_k_reg;
        mv_next      = mv_reg;
        out_next     = out_reg;
        q_pop        = 1'b0;
        rec_we       = 1'b0;
        rec_wa       = k_reg;
        rec_wd       = '0;
        rec_ra       = kc_reg;
        idx_we       = 1'b0;
        idx_wa       = s_reg;
        idx_wd       = '0;
        idx_ra       = s_reg;
        rb_step      = 1'b0;

        if (mv_reg && m_ready) mv_next = 1'b0;

        unique case (state_reg)
            B_INIT: begin
                rec_wa = ci_reg[RA-1:0];
                idx_wa = ci_reg[SW-1:0];
                rec_we = ({1'b0, ci_reg} < (CW + 1)'(RECORDS));
                idx_we = ({1'b0, ci_reg} < (CW + 1)'(INDEX_SLOTS));
                ci_next = ci_reg + CW'(1);
                if (ci_reg == CW'(NMAX - 1)) state_next = B_IDLE;
            end
            B_IDLE: begin
                if (q_valid) begin
                    q_pop        = 1'b1;
                    {func_next, head_next, tail_next, slot_next} = q_data;
                    s_next       = q_data[SW-1:0];
                    pc_next      = '0;
                    found_next   = 1'b0;
                    created_next = 1'b0;
                    evict_next   = 1'b0;
                    fail_next    = 1'b0;
                    raise_next   = 1'b0;
                    has_rec_next = 1'b0;
                    state_next   = B_F_RD;
                end
            end
            B_F_RD: state_next = B_F_IX;
            B_F_IX: begin
                if (idx_rd == '0 || idx_rd > IW'(RECORDS)) begin
                    state_next = B_MISS;
                end else begin
                    rec_ra     = RA'(idx_rd - IW'(1));
                    k_next     = RA'(idx_rd - IW'(1));
                    state_next = B_F_CMP;
                end
            end
            B_F_CMP: begin
                if (rec_rd.valid && rec_rd.head == head_reg && rec_rd.tail == tail_reg) begin
                    found_next   = 1'b1;
                    has_rec_next = 1'b1;
                    cur_next     = rec_rd;
                    state_next   = B_APPLY;
                end else if (pc_reg == SW'(INDEX_SLOTS - 1)) begin
                    state_next = B_MISS;
                end else begin
                    s_next     = s_inc;
                    pc_next    = pc_reg + SW'(1);
                    state_next = B_F_RD;
                end
            end
            B_MISS: begin
                if (func_reg == FN_BUMP_REG || func_reg == FN_CLAIM ||
                    func_reg == FN_BUMP_MOUNT) begin
                    kc_next     = '0;
                    inv_ok_next = 1'b0;
                    z2_ok_next  = 1'b0;
                    m0_ok_next  = 1'b0;
                    state_next  = B_SC_RD;
                end else begin
                    state_next = B_RESP;
                end
            end
            B_SC_RD: state_next = B_SC_CHK;
            B_SC_CHK: begin
                if (!rec_rd.valid && !inv_ok_reg) begin
                    inv_ok_next = 1'b1;
                    inv_k_next  = kc_reg;
                end
                if (rec_rd.valid && rec_rd.mc == '0 && rec_rd.rc == '0 && !z2_ok_reg) begin
                    z2_ok_next = 1'b1;
                    z2_k_next  = kc_reg;
                end
                if (rec_rd.valid && rec_rd.mc == '0 && !m0_ok_reg) begin
                    m0_ok_next = 1'b1;
                    m0_k_next  = kc_reg;
                end
                if (kc_reg == RA'(RECORDS - 1)) begin
                    state_next = B_PICK;
                end else begin
                    kc_next    = kc_reg + RA'(1);
                    state_next = B_SC_RD;
                end
            end
            B_PICK: begin
                if (inv_ok_reg) begin
                    k_next     = inv_k_reg;
                    state_next = B_NEW;
                end else begin
                    priority if (z2_ok_reg) k_next = z2_k_reg;
                    else if (m0_ok_reg)     k_next = m0_k_reg;
                    else                    k_next = '0;
                    // victim is dropped, then the index is rebuilt without it
                    rec_we       = 1'b1;
                    rec_wa       = k_next;
                    evict_next   = 1'b1;
                    rb_fail_next = 1'b0;
                    ci_next      = '0;
                    state_next   = B_RB_CLR;
                end
            end
            B_RB_CLR: begin
                idx_we  = 1'b1;
                idx_wa  = ci_reg[SW-1:0];
                ci_next = ci_reg + CW'(1);
                if (ci_reg == CW'(INDEX_SLOTS - 1)) begin
                    kc_next    = '0;
                    state_next = B_RB_RD;
                end
            end
            B_RB_RD: state_next = B_RB_CHK;
            B_RB_CHK: begin
                if (rec_rd.valid && rec_rd.head[7:0] != 8'd0) begin
                    s_next     = rec_rd.slot;
                    pc_next    = '0;
                    in_rb_next = 1'b1;
                    state_next = B_PL_RD;
                end else begin
                    rb_step = 1'b1;
                end
            end
            B_NEW: begin
                cur_next        = '0;
                cur_next.head   = head_reg;
                cur_next.tail   = tail_reg;
                cur_next.valid  = 1'b1;
                cur_next.slot   = slot_reg;
                rec_we          = 1'b1;
                rec_wd          = cur_next;
                s_next          = slot_reg;
                pc_next         = '0;
                in_rb_next      = 1'b0;
                state_next      = B_PL_RD;
            end
            B_PL_RD: state_next = B_PL_CHK;
            B_PL_CHK: begin
                if (idx_rd == '0) begin
                    idx_we = 1'b1;
                    idx_wd = in_rb_reg ? IW'(kc_reg) + IW'(1) : IW'(k_reg) + IW'(1);
                    if (in_rb_reg) begin
                        rb_step = 1'b1;
                    end else begin
                        created_next = 1'b1;
                        has_rec_next = 1'b1;
                        state_next   = B_APPLY;
                    end
                end else if (pc_reg == SW'(INDEX_SLOTS - 1)) begin
                    if (in_rb_reg) begin
                        rb_step = 1'b1;
                    end else begin
                        // no slot: drop the new record and rebuild
                        rec_we       = 1'b1;
                        fail_next    = 1'b1;
                        rb_fail_next = 1'b1;
                        ci_next      = '0;
                        state_next   = B_RB_CLR;
                    end
                end else begin
                    s_next     = s_inc;
                    pc_next    = pc_reg + SW'(1);
                    state_next = B_PL_RD;
                end
            end
            B_APPLY: begin
                rec_we     = 1'b1;
                rec_wd     = upd;
                cur_next   = upd;
                raise_next = upd_raise;
                state_next = B_RESP;
            end
            B_RESP: begin
                if (!mv_reg || m_ready) begin
                    mv_next                     = 1'b1;
                    out_next.found              = found_reg;
                    out_next.created            = created_reg;
                    out_next.evicted            = evict_reg;
                    out_next.insert_failed      = fail_reg;
                    out_next.register_count     = has_rec_reg ? cur_reg.rc : '0;
                    out_next.mount_count        = has_rec_reg ? cur_reg.mc : '0;
                    out_next.register_exhausted = has_rec_reg && (cur_reg.rc >= limit);
                    out_next.notice_flag        = has_rec_reg && cur_reg.notice;
                    out_next.raise_notice       = raise_reg;
                    state_next                  = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase

        // advance the rebuild walk to the next record
        if (rb_step) begin
            if (kc_reg == RA'(RECORDS - 1)) begin
                state_next = rb_fail_reg ? B_RESP : B_NEW;
            end else begin
                kc_next    = kc_reg + RA'(1);
                state_next = B_RB_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_we) rec_mem[rec_wa] <= rec_wd;
        rec_rd <= rec_mem[rec_ra];
    end

    always_ff @(posedge aclk) begin
        if (idx_we) idx_mem[idx_wa] <= idx_wd;
        idx_rd <= idx_mem[idx_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_INIT;
            ci_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ci_reg    <= ci_next;
            mv_reg    <= mv_next;
        end
        func_reg    <= func_next;
        head_reg    <= head_next;
        tail_reg    <= tail_next;
        slot_reg    <= slot_next;
        s_reg       <= s_next;
        pc_reg      <= pc_next;
        k_reg       <= k_next;
        kc_reg      <= kc_next;
        cur_reg     <= cur_next;
        found_reg   <= found_next;
        created_reg <= created_next;
        evict_reg   <= evict_next;
        fail_reg    <= fail_next;
        raise_reg   <= raise_next;
        has_rec_reg <= has_rec_next;
        in_rb_reg   <= in_rb_next;
        rb_fail_reg <= rb_fail_next;
        inv_ok_reg  <= inv_ok_next;
        z2_ok_reg   <= z2_ok_next;
        m0_ok_reg   <= m0_ok_next;
        inv_k_reg   <= inv_k_next;
        z2_k_reg    <= z2_k_next;
        m0_k_reg    <= m0_k_next;
        out_reg     <= out_next;
    end
endmodule

// ----- src/keyed_attempt_counter_table_core.sv -----
// Keyed attempt counter table, top level: front end, queue, table sequencer, assertions.
// After reset the block clears its record and index memories, and s_ready stays low until
// the clear is done. Each word then goes through the front end: FNV-1a hashing of the key
// bytes up to the end of the key (one 32x32 multiply a cycle), then reciprocal-multiply
// reduction to an index slot (multiply, subtract, correct) and a push to the queue; the
// front end takes no new word until that push, which waits while the queue is full. The
// table sequencer, fed through a two-entry queue, pops a word, probes the index (index
// read, record read, compare), applies the op and loads the result register. Creating a
// record scans all records; an eviction or failed insert adds an index rebuild.
// The front end can hash the next word while the sequencer is busy with the last one; the
// sequencer takes one word at a time.
module keyed_attempt_counter_table_core import kact_pkg::*; #(
    parameter int RECORDS     = 64,
    parameter int INDEX_SLOTS = 128
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata
);
    localparam int SW = $clog2(INDEX_SLOTS);
    localparam int W  = 3 + 64 + 8 + SW;

    logic [7:0]   limit_reg;
    logic         init_done;
    logic         q_push, q_full, q_pop, q_nonempty;
    logic [W-1:0] q_wdata, q_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    kact_front #(.INDEX_SLOTS(INDEX_SLOTS), .SW(SW), .W(W)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(init_done),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_push(q_push), .q_full(q_full), .q_data(q_wdata)
    );

    kact_queue #(.W(W)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .wdata(q_wdata), .full(q_full),
        .pop(q_pop), .nonempty(q_nonempty), .rdata(q_rdata)
    );

    kact_back #(.RECORDS(RECORDS), .INDEX_SLOTS(INDEX_SLOTS), .SW(SW), .W(W)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_nonempty), .q_data(q_rdata), .q_pop(q_pop),
        .limit(limit_reg), .init_done(init_done),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    a_created_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.created && m_data.found))
        else $error("word both found and created");

    a_evict_needs_create: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.evicted |-> m_data.created || m_data.insert_failed)
        else $error("eviction without a creation attempt");

    a_raise_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.raise_notice |-> m_data.notice_flag && !m_data.insert_failed)
        else $error("notice raised but flag clear");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_ready && !q_nonempty)
        else $error("word taken during memory clear");
endmodule
